### rtl/three_level_priority_queue_macros.svh
// Assertion macros for the three-level priority queue checker.
// Each expects a clock named clk and a reset named rst in scope.
`ifndef THREE_LEVEL_PRIORITY_QUEUE_MACROS_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_MACROS_SVH

// Property must hold at every edge outside reset.
`define TLPQ_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold at the clock edge after the antecedent.
`define TLPQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tlpq_pkg.sv
// ----------------------------------------------------------------------------
// tlpq_pkg
// Shared constants, codes and types of the three-level priority queue.
// ----------------------------------------------------------------------------
package tlpq_pkg;

  localparam int DEPTH  = 16;  // entries per level ring
  localparam int LEVELS = 3;   // priority levels, 1 highest

  localparam int ID_W   = 32;
  localparam int LVL_W  = 2;
  localparam int STAT_W = 2;

  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int Q_W    = $clog2(LEVELS);
  localparam int ADDR_W = (LEVELS * DEPTH > 1) ? $clog2(LEVELS * DEPTH) : 1;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  localparam logic [STAT_W-1:0] ST_ENQUEUED = 2'd0;
  localparam logic [STAT_W-1:0] ST_SERVED   = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_DROPPED  = 2'd3;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ID_W-1:0]   wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

### rtl/tlpq_if.sv
// ----------------------------------------------------------------------------
// tlpq_if
// Valid/ready channels: operation requests in, results out.
// ----------------------------------------------------------------------------
interface tlpq_in_if import tlpq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [ID_W-1:0]  entry_id;
  logic [LVL_W-1:0] level;

  modport source (output valid, kind, entry_id, level, input ready);
  modport sink   (input valid, kind, entry_id, level, output ready);
endinterface

interface tlpq_out_if import tlpq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   served_id;
  logic [LVL_W-1:0]  served_level;

  modport source (output valid, status, served_id, served_level, input ready);
  modport sink   (input valid, status, served_id, served_level, output ready);
endinterface

### rtl/tlpq_store.sv
// ----------------------------------------------------------------------------
// tlpq_store
// Entry memory: one slot per level and ring position, registered read.
// ----------------------------------------------------------------------------
module tlpq_store import tlpq_pkg::*; (
  input  logic            clk,
  input  mem_req_t        mem_req,
  output logic [ID_W-1:0] rd_data
);

  logic [ID_W-1:0] mem [LEVELS*DEPTH];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
    if (mem_req.re) begin
      rd_data <= mem[mem_req.raddr];
    end
  end

endmodule

### rtl/tlpq_ctrl.sv
// ----------------------------------------------------------------------------
// tlpq_ctrl
// Ring pointers, level counts, priority pick, sequencer and result register.
// ----------------------------------------------------------------------------
module tlpq_ctrl import tlpq_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  tlpq_in_if.sink         req,
  tlpq_out_if.source      rsp,
  output mem_req_t        mem_req,
  input  logic [ID_W-1:0] rd_data
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic             state;
  logic [PTR_W-1:0] head [LEVELS];
  logic [PTR_W-1:0] tail [LEVELS];
  logic [CNT_W-1:0] count [LEVELS];
  logic [Q_W-1:0]   pend_q;

  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [ID_W-1:0]   out_id;
  logic [LVL_W-1:0]  out_level;

  logic             fire;
  logic             lvl_ok;
  logic [Q_W-1:0]   eq;
  logic             enq_ok;
  logic             any;
  logic [Q_W-1:0]   dq;
  logic             out_load;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (32'(p) == DEPTH - 1) ? '0 : PTR_W'(32'(p) + 1);
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [Q_W-1:0] q,
                                                 input logic [PTR_W-1:0] p);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(32'(q) * DEPTH + 32'(p));
    return a;
  endfunction

  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign fire      = req.valid && req.ready;

  // enqueue target; level 0 or above LEVELS is dropped
  assign lvl_ok = (req.level != '0) && (32'(req.level) <= LEVELS);
  assign eq     = Q_W'(32'(req.level) - 1);
  assign enq_ok = lvl_ok && (32'(count[eq]) < DEPTH);

  // result register takes a new beat: served entry after the read, or
  // an immediate answer for enqueue and empty dequeue
  assign out_load = (state == S_READ) ||
                    (fire && !((req.kind == KIND_DEQ) && any));

  // highest non-empty level: lowest index wins
  always_comb begin
    any = 1'b0;
    dq  = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (count[i] != '0) begin
        any = 1'b1;
        dq  = Q_W'(i);
      end
    end
  end

  always_comb begin
    mem_req.we    = fire && (req.kind == KIND_ENQ) && enq_ok;
    mem_req.waddr = slot_addr(eq, tail[eq]);
    mem_req.wdata = req.entry_id;
    mem_req.re    = fire && (req.kind == KIND_DEQ) && any;
    mem_req.raddr = slot_addr(dq, head[dq]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (fire) begin
            if (req.kind == KIND_ENQ) begin
              out_id    <= '0;
              out_level <= '0;
              if (enq_ok) begin
                tail[eq]   <= ring_next(tail[eq]);
                count[eq]  <= count[eq] + 1'b1;
                out_status <= ST_ENQUEUED;
              end else begin
                out_status <= ST_DROPPED;
              end
            end else if (any) begin
              head[dq]  <= ring_next(head[dq]);
              count[dq] <= count[dq] - 1'b1;
              pend_q    <= dq;
              state     <= S_READ;
            end else begin
              out_status <= ST_EMPTY;
              out_id     <= '0;
              out_level  <= '0;
            end
          end
        end
        S_READ: begin
          out_status <= ST_SERVED;
          out_id     <= rd_data;
          out_level  <= LVL_W'(32'(pend_q) + 1);
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.served_id    = out_id;
  assign rsp.served_level = out_level;

endmodule

### rtl/three_level_priority_queue.sv
// ----------------------------------------------------------------------------
// three_level_priority_queue
// Strict priority queue, three levels, one ring per level in a shared memory.
// ----------------------------------------------------------------------------
// Usage:
//   req  : valid/ready channel; each beat is one operation. kind 0 enqueues
//          entry_id at level (1 highest), kind 1 dequeues the oldest entry
//          of the highest non-empty level.
//   rsp  : valid/ready channel; exactly one beat per request beat, in order.
//          status: enqueued, served, queue empty, or dropped (level full or
//          level out of range). served_id/served_level are zero unless
//          an entry was served.
// Order: enqueue and empty dequeue answer straight from the result register,
//   loaded at the request beat; a serving dequeue first reads the entry
//   memory (registered read, state S_READ), then loads the result register.
//   One operation is in flight at a time.
// Reset (rst, synchronous): all levels empty, pointers zero, no result
//   pending. The entry memory is not cleared; slots are read only after
//   being written.
// Stall: the result register holds its beat while rsp.ready is low and
//   req.ready stays low until that beat leaves (it may go in the same cycle).
// ----------------------------------------------------------------------------
module three_level_priority_queue import tlpq_pkg::*; (
  input logic        clk,
  input logic        rst,
  tlpq_in_if.sink    req,
  tlpq_out_if.source rsp
);

  mem_req_t        mem_req;   // write on enqueue into a non-full level, read on serving dequeue
  logic [ID_W-1:0] rd_data;   // served id, valid the cycle after the read

  tlpq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  tlpq_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

endmodule

### rtl/tlpq_checker.sv
// ----------------------------------------------------------------------------
// tlpq_checker
// Port-level checks of the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "three_level_priority_queue_macros.svh"

module tlpq_checker import tlpq_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [STAT_W-1:0] status,
  input logic [ID_W-1:0]   served_id,
  input logic [LVL_W-1:0]  served_level
);

  logic req_fire;
  assign req_fire = req_valid && req_ready;

  `TLPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(served_id) && $stable(served_level), "stalled result beat changed")
  `TLPQ_ASSERT(a_fields, !rsp_valid || (status == ST_SERVED ? served_level != '0 : (served_id == '0 && served_level == '0)), "result fields inconsistent with status")
  `TLPQ_ASSERT(a_rsp_cause, !$rose(rsp_valid) || $past(req_fire) || $past(req_fire, 2), "result beat without a request")
  `TLPQ_ASSERT(a_no_accept_stalled, !(rsp_valid && !rsp_ready) || !req_ready, "request taken while result stalled")

endmodule

bind three_level_priority_queue tlpq_checker u_tlpq_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .status       (rsp.status),
  .served_id    (rsp.served_id),
  .served_level (rsp.served_level)
);
